// ----- rtl/line_edge_subpixel_locator_core_macros.svh -----
// Assertion macros used by the line edge locator top level.
`ifndef LINE_EDGE_SUBPIXEL_LOCATOR_CORE_MACROS_SVH
`define LINE_EDGE_SUBPIXEL_LOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on i_clk and disabled while in reset.
`define LESL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk and disabled while in reset.
`define LESL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LESL_ASSERT_IMPL(label, ante, cons, msg)
`define LESL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/lesl_pkg.sv -----
// Types and constants shared by the line edge locator modules.
package lesl_pkg;

    localparam int PIX_W       = 16;
    localparam int SUM_W       = 19;
    localparam int D_W         = 24;
    localparam int THR_W       = 22;
    localparam int POS_W       = 21;
    localparam int TDATA_OUT_W = 24;

    localparam int LEN_W    = 13;
    localparam int THRESH_W = 16;
    localparam int MARGIN_W = 10;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [LEN_W-1:0]    LEN_RST    = 13'd2048;
    localparam logic [THRESH_W-1:0] THRESH_RST = 16'd50;
    localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd20;
    localparam logic [MARGIN_W-1:0] MIN_MARGIN = 10'd5;
    localparam int                  MIN_LINE   = 10;
    localparam int                  SUM_START  = 4;
    localparam int                  SLOPE_START = 8;
    localparam logic [5:0]          SLOPE_SCALE = 6'd60;

    typedef enum logic [1:0] {
        REG_LINE_LENGTH    = 2'd0,
        REG_EDGE_THRESHOLD = 2'd1,
        REG_SEARCH_MARGIN  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [LEN_W-1:0]    line_length;
        logic [THRESH_W-1:0] edge_threshold;
        logic [MARGIN_W-1:0] search_margin;
    } t_cfg;

    typedef struct packed {
        logic step;
        logic prep;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic line_end;
        logic out_busy;
    } t_status;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/line_edge_subpixel_locator_core.sv -----
// Top level of the line edge locator with sub-pixel refinement.
//
//   port group   dir   width  contents
//   s_axis_*     in    16     one pixel per word
//   m_axis_*     out   24+1   edge position in tdata, found flag in tuser
//   APB          in    4/32   line_length, edge_threshold, search_margin
//
// Pixels are accepted while s_axis_tready is high. The pixel that ends a line is followed
// by a setup state, the bit-serial offset divider, which forms 24 + FRAC_BITS quotient bits,
// and a load state that waits until the output register is free; s_axis_tready is low meanwhile.
// A synchronous reset restores the register defaults and clears the line state.
// A result waits in the output register; pixels of the next line are accepted meanwhile.
`include "line_edge_subpixel_locator_core_macros.svh"
module line_edge_subpixel_locator_core import lesl_pkg::*; #(
    parameter int MAX_PIXELS = 4096,
    parameter int FRAC_BITS  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,  // [15:0] pixel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // [20:0] edge_position, [23:21] zero
    output logic [0:0]             m_axis_tuser,  // [0] edge_found
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    t_cfg             w_cfg;
    t_cmd             w_cmd;
    t_status          w_status;
    logic             w_found;
    logic [POS_W-1:0] w_pos;

    lesl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lesl_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_status  (w_status),
        .o_s_ready (s_axis_tready),
        .o_cmd     (w_cmd)
    );

    lesl_dpath #(
        .MAX_PIXELS (MAX_PIXELS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_pixel    (s_axis_tdata),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_found    (w_found),
        .o_position (w_pos)
    );

    assign m_axis_tdata = {{(TDATA_OUT_W - POS_W){1'b0}}, w_pos};
    assign m_axis_tuser = w_found;

    `LESL_ASSERT_IMPL(a_empty_pos, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "position not zero without an edge")
    `LESL_ASSERT_NEXT(a_line_end_stall, s_axis_tvalid && s_axis_tready && w_status.line_end, !s_axis_tready, "pixel accepted during end-of-line divide")
    `LESL_ASSERT_IMPL(a_load_free, w_cmd.load_out, !(m_axis_tvalid && !m_axis_tready), "result loaded over a waiting word")

endmodule

// ----- rtl/lesl_regs.sv -----
// Configuration register file behind the APB-style port.
module lesl_regs import lesl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_length    <= LEN_RST;
            r_cfg.edge_threshold <= THRESH_RST;
            r_cfg.search_margin  <= MARGIN_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_LINE_LENGTH:    r_cfg.line_length    <= pwdata[LEN_W-1:0];
                REG_EDGE_THRESHOLD: r_cfg.edge_threshold <= pwdata[THRESH_W-1:0];
                REG_SEARCH_MARGIN:  r_cfg.search_margin  <= pwdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LINE_LENGTH:    prdata = APB_DW'(r_cfg.line_length);
            REG_EDGE_THRESHOLD: prdata = APB_DW'(r_cfg.edge_threshold);
            REG_SEARCH_MARGIN:  prdata = APB_DW'(r_cfg.search_margin);
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- rtl/lesl_ctrl.sv -----
// Controller state machine: pixel intake, end-of-line divide and result hand-off.
module lesl_ctrl import lesl_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  t_status i_status,
    output logic    o_s_ready,
    output t_cmd    o_cmd
);

    localparam int NUM_W  = D_W + FRAC_BITS;
    localparam int ITER_W = $clog2(NUM_W);

    t_state              r_state, n_state;
    logic [ITER_W-1:0]   r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        case (r_state)
            ST_RUN: begin
                if (i_s_valid && i_status.line_end) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_iter  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_W'(NUM_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        o_s_ready = 1'b0;
        o_cmd     = '0;
        case (r_state)
            ST_RUN: begin
                o_s_ready  = 1'b1;
                o_cmd.step = i_s_valid;
            end
            ST_PREP: o_cmd.prep     = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_DONE: o_cmd.load_out = !i_status.out_busy;
            default: ;
        endcase
    end

endmodule

// ----- rtl/lesl_dpath.sv -----
// Datapath: running sums, slope, minimum tracking, offset divider and result register.
module lesl_dpath import lesl_pkg::*; #(
    parameter int MAX_PIXELS = 4096,
    parameter int FRAC_BITS  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    output logic             o_found,
    output logic [POS_W-1:0] o_position
);

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int CMP_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int NUM_W  = D_W + FRAC_BITS;
    localparam int DIFF_W = D_W + 1;
    localparam int DEN_W  = D_W + 2;
    localparam int OFF_W  = FRAC_BITS + 1;
    localparam int SH_W   = CNT_W + FRAC_BITS;
    localparam int WIDE_W = (SH_W > POS_W) ? SH_W : POS_W;
    localparam logic [NUM_W-1:0] ONE_Q = NUM_W'(1) << FRAC_BITS;

    logic [PIX_W-1:0]        r_pix [4];
    logic [SUM_W-1:0]        r_sum [4];
    logic signed [D_W-1:0]   r_hist, r_bl, r_bc, r_br;
    logic signed [D_W-1:0]   n_hist, n_bl, n_bc, n_br;
    logic [CNT_W-1:0]        r_idx, n_idx, r_cnt, n_cnt;
    logic                    r_have, n_have, r_await, n_await;

    logic signed [D_W-1:0]   r_op_bl, r_op_bc, r_op_br;
    logic [CNT_W-1:0]        r_op_idx;
    logic                    r_op_have;

    logic                    r_found, r_neg, r_den0;
    logic [DEN_W-1:0]        r_dmag, r_rem;
    logic [NUM_W-1:0]        r_quo;

    logic                    r_out_valid, r_out_found;
    logic [POS_W-1:0]        r_out_pos;

    logic [CMP_W-1:0]        len_raw, eff_len, p_ext, p1, j, jm;
    logic [MARGIN_W-1:0]     eff_margin;
    logic [SUM_W-1:0]        s;
    logic signed [D_W-1:0]   d, ref_slope;
    logic                    sum_en, slope_en, cand, line_end;

    assign len_raw = CMP_W'(i_cfg.line_length);
    always_comb begin
        if (len_raw == '0) begin
            eff_len = CMP_W'(1);
        end else if (len_raw > CMP_W'(MAX_PIXELS)) begin
            eff_len = CMP_W'(MAX_PIXELS);
        end else begin
            eff_len = len_raw;
        end
    end
    assign eff_margin = (i_cfg.search_margin < MIN_MARGIN) ? MIN_MARGIN : i_cfg.search_margin;

    assign p_ext    = CMP_W'(r_cnt);
    assign p1       = p_ext + 1'b1;
    assign line_end = (p1 >= eff_len);
    assign sum_en   = (r_cnt >= CNT_W'(SUM_START));
    assign slope_en = (r_cnt >= CNT_W'(SLOPE_START));
    assign j        = p_ext - CMP_W'(SUM_START);
    assign jm       = j + CMP_W'(eff_margin);

    assign s = SUM_W'(i_pixel) + SUM_W'(r_pix[0]) + SUM_W'(r_pix[1])
             + SUM_W'(r_pix[2]) + SUM_W'(r_pix[3]);
    assign d = $signed(D_W'(r_sum[3])) - ($signed(D_W'(r_sum[2])) <<< 3)
             + ($signed(D_W'(r_sum[0])) <<< 3) - $signed(D_W'(s));
    assign ref_slope = r_have ? r_bc : '0;
    assign cand = slope_en && (j >= CMP_W'(eff_margin)) && (jm < eff_len) && (d < ref_slope);

    always_comb begin
        n_cnt   = r_cnt;
        n_hist  = r_hist;
        n_bl    = r_bl;
        n_bc    = r_bc;
        n_br    = r_br;
        n_idx   = r_idx;
        n_have  = r_have;
        n_await = r_await;
        if (i_cmd.step) begin
            n_cnt = r_cnt + 1'b1;
            if (slope_en) begin
                if (r_await) begin
                    n_br    = d;
                    n_await = 1'b0;
                end
                if (cand) begin
                    n_bl    = r_hist;
                    n_bc    = d;
                    n_br    = '0;
                    n_idx   = j[CNT_W-1:0];
                    n_have  = 1'b1;
                    n_await = 1'b1;
                end
                n_hist = d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_hist  <= '0;
            r_bl    <= '0;
            r_bc    <= '0;
            r_br    <= '0;
            r_idx   <= '0;
            r_have  <= 1'b0;
            r_await <= 1'b0;
        end else if (i_cmd.step && line_end) begin
            r_cnt   <= '0;
            r_hist  <= '0;
            r_bl    <= '0;
            r_bc    <= '0;
            r_br    <= '0;
            r_idx   <= '0;
            r_have  <= 1'b0;
            r_await <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_hist  <= n_hist;
            r_bl    <= n_bl;
            r_bc    <= n_bc;
            r_br    <= n_br;
            r_idx   <= n_idx;
            r_have  <= n_have;
            r_await <= n_await;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pix[0] <= i_pixel;
            r_pix[1] <= r_pix[0];
            r_pix[2] <= r_pix[1];
            r_pix[3] <= r_pix[2];
            if (sum_en) begin
                r_sum[0] <= s;
                r_sum[1] <= r_sum[0];
                r_sum[2] <= r_sum[1];
                r_sum[3] <= r_sum[2];
            end
            if (line_end) begin
                r_op_bl   <= n_bl;
                r_op_bc   <= n_bc;
                r_op_br   <= n_br;
                r_op_idx  <= n_idx;
                r_op_have <= n_have && (p1 >= CMP_W'(MIN_LINE));
            end
        end
    end

    logic [THR_W-1:0]         thr;
    logic signed [D_W:0]      lim;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DEN_W-1:0]  den;
    logic [DIFF_W-1:0]        diff_mag;
    logic [DEN_W-1:0]         den_mag;
    logic [DEN_W:0]           rem_sh;
    logic                     ge;

    assign thr      = THR_W'(i_cfg.edge_threshold) * THR_W'(SLOPE_SCALE);
    assign lim      = $signed({r_op_bc[D_W-1], r_op_bc}) + $signed((D_W + 1)'(thr));
    assign diff     = $signed({r_op_bl[D_W-1], r_op_bl}) - $signed({r_op_br[D_W-1], r_op_br});
    assign den      = $signed({{2{r_op_bl[D_W-1]}}, r_op_bl})
                    - ($signed({{2{r_op_bc[D_W-1]}}, r_op_bc}) <<< 1)
                    + $signed({{2{r_op_br[D_W-1]}}, r_op_br});
    assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign den_mag  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    assign rem_sh   = {r_rem, r_quo[NUM_W-1]};
    assign ge       = (rem_sh >= {1'b0, r_dmag});

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_found <= r_op_have && (lim[D_W] || (lim == '0));
            r_neg   <= diff[DIFF_W-1] ^ den[DEN_W-1];
            r_den0  <= (den == '0);
            r_dmag  <= den_mag;
            r_rem   <= '0;
            r_quo   <= {diff_mag, {(FRAC_BITS - 1){1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? DEN_W'(rem_sh - {1'b0, r_dmag}) : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    logic [NUM_W-1:0]  q_sat;
    logic [OFF_W-1:0]  off_mag;
    logic [POS_W-1:0]  off_pos, off_s, pos;
    logic [WIDE_W-1:0] idx_sh;

    assign q_sat   = (r_quo > ONE_Q) ? ONE_Q : r_quo;
    assign off_mag = r_den0 ? '0 : q_sat[OFF_W-1:0];
    assign off_pos = POS_W'(off_mag);
    assign off_s   = r_neg ? (~off_pos + 1'b1) : off_pos;
    assign idx_sh  = WIDE_W'({r_op_idx, {FRAC_BITS{1'b0}}});
    assign pos     = idx_sh[POS_W-1:0] + off_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_found <= r_found;
            r_out_pos   <= r_found ? pos : '0;
        end
    end

    assign o_status.line_end = line_end;
    assign o_status.out_busy = r_out_valid && !i_m_ready;
    assign o_m_valid  = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

endmodule
